// ----- rtl/npnp_pkg.sv -----
// ============================================================================
// npnp_pkg: shared types and constants of the palette nibble packer
// Holds the palette reset colors, field widths and the distance function.
// ============================================================================
package npnp_pkg;

    localparam int COLOR_W     = 24;
    localparam int CHAN_W      = 8;
    localparam int NUM_REGS    = 8;
    localparam int REG_W       = 3;
    localparam int CFG_IDX_W   = 8;
    localparam int ENTRY_MAX   = 16;
    localparam int IDX_W       = 4;
    localparam int SUM_W       = 18;
    localparam int DIST_W      = SUM_W + 1;
    localparam int BYTE_W      = 2 * IDX_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef logic [COLOR_W-1:0]   t_color;
    typedef logic [CHAN_W-1:0]    t_chan;
    typedef logic [DIST_W-1:0]    t_dist;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [BYTE_W-1:0]    t_byte;

    localparam t_color RESET_PALETTE [NUM_REGS] = '{
        24'h000000, 24'hFFFFFF, 24'h438A1C, 24'h6440FF,
        24'hBF0000, 24'hFFF338, 24'hE87E00, 24'hC2A4F4
    };

    function automatic logic [2*CHAN_W-1:0] sq_diff(input t_chan a, input t_chan b);
        t_chan d;
        d = (a >= b) ? (a - b) : (b - a);
        return d * d;
    endfunction

    function automatic logic [SUM_W-1:0] color_dist(input t_chan r, input t_chan g,
                                                    input t_chan b, input t_color c);
        return SUM_W'(sq_diff(r, c[23:16])) + SUM_W'(sq_diff(g, c[15:8]))
             + SUM_W'(sq_diff(b, c[7:0]));
    endfunction

endpackage

// ----- rtl/npnp_pix_if.sv -----
// ============================================================================
// npnp_pix_if: pixel channel
// Valid/ready channel carrying one 8-bit RGB pixel per beat.
// ============================================================================
interface npnp_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source(output valid, red, green, blue, input ready);
    modport sink(input valid, red, green, blue, output ready);
endinterface

// ----- rtl/npnp_byte_if.sv -----
// ============================================================================
// npnp_byte_if: packed byte channel
// Valid/ready channel carrying one byte of two palette indexes per beat.
// ============================================================================
interface npnp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;

    modport source(output valid, packed_byte, input ready);
    modport sink(input valid, packed_byte, output ready);
endinterface

// ----- rtl/npnp_cfg_if.sv -----
// ============================================================================
// npnp_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ============================================================================
interface npnp_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [23:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/npnp_front.sv -----
// ============================================================================
// npnp_front: palette registers and nearest-color search
// Computes all palette distances in one stage, then picks the minimum through
// a four-level registered tree where the lower index wins on a tie.
// ============================================================================
module npnp_front #(
    parameter int PALETTE_SIZE = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    npnp_pix_if.sink         i_pix,
    npnp_cfg_if.sink         i_cfg,
    output logic             o_valid,
    input  logic             i_ready,
    output npnp_pkg::t_idx   o_idx
);
    import npnp_pkg::*;

    t_color r_pal [NUM_REGS];
    t_color w_color [ENTRY_MAX];
    t_dist  w_dist [ENTRY_MAX];
    logic   w_cfg_hit;
    logic   w_en;
    logic   r_v0, r_v1, r_v2, r_v3, r_v4;
    t_dist  r_d0 [ENTRY_MAX];
    t_dist  r_d1 [8];
    t_idx   r_i1 [8];
    t_dist  r_d2 [4];
    t_idx   r_i2 [4];
    t_dist  r_d3 [2];
    t_idx   r_i3 [2];
    t_idx   r_i4;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_hit   = i_cfg.valid && (int'(i_cfg.index) < NUM_REGS)
                      && (int'(i_cfg.index) < PALETTE_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_pal[k] <= RESET_PALETTE[k];
            end
        end else if (w_cfg_hit) begin
            r_pal[i_cfg.index[REG_W-1:0]] <= i_cfg.data;
        end
    end

    for (genvar e = 0; e < ENTRY_MAX; e++) begin : g_entry
        if (e < NUM_REGS) begin : g_reg
            assign w_color[e] = r_pal[e];
        end else begin : g_zero
            assign w_color[e] = '0;
        end
        if (e < PALETTE_SIZE) begin : g_used
            assign w_dist[e] = {1'b0, color_dist(i_pix.red, i_pix.green, i_pix.blue,
                                                 w_color[e])};
        end else begin : g_unused
            assign w_dist[e] = '1;
        end
    end

    assign w_en        = !r_v4 || i_ready;
    assign i_pix.ready = w_en;
    assign o_valid     = r_v4;
    assign o_idx       = r_i4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_pix.valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < ENTRY_MAX; k++) begin
                r_d0[k] <= w_dist[k];
            end
            for (int k = 0; k < 8; k++) begin
                if (r_d0[2*k+1] < r_d0[2*k]) begin
                    r_d1[k] <= r_d0[2*k+1];
                    r_i1[k] <= IDX_W'(2*k+1);
                end else begin
                    r_d1[k] <= r_d0[2*k];
                    r_i1[k] <= IDX_W'(2*k);
                end
            end
            for (int k = 0; k < 4; k++) begin
                if (r_d1[2*k+1] < r_d1[2*k]) begin
                    r_d2[k] <= r_d1[2*k+1];
                    r_i2[k] <= r_i1[2*k+1];
                end else begin
                    r_d2[k] <= r_d1[2*k];
                    r_i2[k] <= r_i1[2*k];
                end
            end
            for (int k = 0; k < 2; k++) begin
                if (r_d2[2*k+1] < r_d2[2*k]) begin
                    r_d3[k] <= r_d2[2*k+1];
                    r_i3[k] <= r_i2[2*k+1];
                end else begin
                    r_d3[k] <= r_d2[2*k];
                    r_i3[k] <= r_i2[2*k];
                end
            end
            r_i4 <= (r_d3[1] < r_d3[0]) ? r_i3[1] : r_i3[0];
        end
    end

endmodule

// ----- rtl/npnp_fifo.sv -----
// ============================================================================
// npnp_fifo: index queue
// Four-entry queue of palette indexes between the search and the packer.
// ============================================================================
module npnp_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  npnp_pkg::t_idx i_idx,
    output logic           o_valid,
    input  logic           i_ready,
    output npnp_pkg::t_idx o_idx
);
    import npnp_pkg::*;

    t_idx              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_idx   = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/npnp_back.sv -----
// ============================================================================
// npnp_back: nibble packer
// Holds the index of the first pixel of a pair and emits one byte after the
// second, through an output register.
// ============================================================================
module npnp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  npnp_pkg::t_idx i_idx,
    npnp_byte_if.source    o_byte
);
    import npnp_pkg::*;

    t_idx  r_held;
    logic  r_pending;
    logic  r_out_valid;
    t_byte r_out_data;
    logic  w_acc;

    assign o_ready            = !r_pending || !r_out_valid || o_byte.ready;
    assign w_acc              = i_valid && o_ready;
    assign o_byte.valid       = r_out_valid;
    assign o_byte.packed_byte = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc && !r_pending) begin
                r_held    <= i_idx;
                r_pending <= 1'b1;
            end else if (w_acc) begin
                r_pending   <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (o_byte.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_acc && !r_pending && o_byte.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && r_pending) begin
            r_out_data <= {r_held, i_idx};
        end
    end

    a_byte_follows_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_pending) |=> r_out_valid)
        else $error("Second index of a pair did not produce a byte.");

    a_pending_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_pending != $past(r_pending)))
        else $error("Pair phase did not advance on an accepted index.");

    a_held_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(r_held))
        else $error("Held index changed without an accepted index.");

endmodule

// ----- rtl/nearest_palette_nibble_packer.sv -----
// ============================================================================
// nearest_palette_nibble_packer: nearest palette color with nibble packing
// Maps each RGB pixel to the closest of the palette colors and packs the
// indexes of each pixel pair into one byte, first pixel in the high nibble.
//
//   Port     Direction  Beat
//   i_pix    in         one pixel: red, green, blue
//   i_cfg    in         one palette register write: index, data
//   o_byte   out        one packed byte per two pixels
//
// One pixel is accepted per cycle while the search pipeline is not stalled.
// A pixel passes the distance stage and the four-level minimum tree, then
// a four-entry queue to the packer, which has an output register.
// Reset is synchronous and restores the default palette and the pair phase.
// A stall on o_byte fills the queue first and then stops i_pix.
// ============================================================================
module nearest_palette_nibble_packer #(
    parameter int PALETTE_SIZE = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    npnp_pix_if.sink    i_pix,
    npnp_cfg_if.sink    i_cfg,
    npnp_byte_if.source o_byte
);
    import npnp_pkg::*;

    logic w_f_valid;
    logic w_f_ready;
    t_idx w_f_idx;
    logic w_b_valid;
    logic w_b_ready;
    t_idx w_b_idx;

    npnp_front #(
        .PALETTE_SIZE(PALETTE_SIZE)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (i_pix),
        .i_cfg  (i_cfg),
        .o_valid(w_f_valid),
        .i_ready(w_f_ready),
        .o_idx  (w_f_idx)
    );

    npnp_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_f_valid),
        .o_ready(w_f_ready),
        .i_idx  (w_f_idx),
        .o_valid(w_b_valid),
        .i_ready(w_b_ready),
        .o_idx  (w_b_idx)
    );

    npnp_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_b_valid),
        .o_ready(w_b_ready),
        .i_idx  (w_b_idx),
        .o_byte (o_byte)
    );

endmodule
